### sv/mtep_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the MIDI track event parser.
// No dependencies.
package mtep_pkg;

  localparam int VARLEN_MAX_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] MSB_MASK   = 8'h80;
  localparam logic [7:0] DATA_MASK  = 8'h7F;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_ESCAPE  = 8'hF7;
  localparam logic [7:0] META_EOT   = 8'h2F;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_VARLEN    = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_METATYPE,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [31:0] abs_tick;
    logic [7:0]  status_byte;
    logic [7:0]  meta_kind;
    logic [27:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_event;
    logic        end_of_track;
    logic [1:0]  error_code;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [31:0] tick,
                                  input logic [7:0] rs, input logic [7:0] mt,
                                  input logic [27:0] plen, input logic [7:0] pbyte,
                                  input logic last, input logic eot,
                                  input logic [1:0] err);
    res_t r;
    r.item_kind      = kind;
    r.abs_tick       = tick;
    r.status_byte    = rs;
    r.meta_kind      = (rs == ST_META) ? mt : 8'h00;
    r.payload_length = plen;
    r.payload_byte   = pbyte;
    r.last_of_event  = last;
    r.end_of_track   = eot;
    r.error_code     = err;
    return r;
  endfunction

endpackage

### sv/midi_track_event_parser_core.sv
`timescale 1ns / 1ps
// Top level of the MIDI track event parser.
// Depends on mtep_pkg, mtep_front, mtep_queue, mtep_back.
//
// Input channel: one track byte per word with track_start / track_end marks,
// taken when data_valid is high and data_stall low.
// Output channel: result words (event header, payload byte, error), handed
// over when item_valid is high and item_stall low.
// Each byte is parsed in the cycle it is taken and gives zero, one or two
// result words, which enter a four-word queue. The words of a byte are
// written into the queue when the byte is taken and then pass through the
// output register; a second word follows the first.
// Throughput: one byte per cycle while data_stall is low; two words of a
// byte leave singly, so the queue fills; data_stall rises until it drains.
// data_stall is high while the queue holds more than two words.
// Reset clears the parse state (as at a track start) and empties the queue.
// While item_stall is high the output word holds and the queue fills.
module midi_track_event_parser_core #(
  parameter int VARLEN_MAX_BYTES = mtep_pkg::VARLEN_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        track_start,
  input  logic        track_end,
  output logic        item_valid,
  input  logic        item_stall,
  output logic [1:0]  item_kind,
  output logic [31:0] abs_tick,
  output logic [7:0]  status_byte,
  output logic [7:0]  meta_kind,
  output logic [27:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        last_of_event,
  output logic        end_of_track,
  output logic [1:0]  error_code
);

  mtep_pkg::push_t push;
  mtep_pkg::res_t  head, item;
  logic            nonempty, full, pop, accept;

  assign data_stall = full;
  assign accept     = data_valid && !full;

  mtep_front #(.VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .data_byte(data_byte),
    .track_start(track_start), .track_end(track_end), .push(push)
  );

  mtep_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .pop(pop),
    .head(head), .nonempty(nonempty), .full(full)
  );

  mtep_back u_back (
    .clk(clk), .rst(rst), .head(head), .nonempty(nonempty), .pop(pop),
    .item_stall(item_stall), .item_valid(item_valid), .item(item)
  );

  assign item_kind      = item.item_kind;
  assign abs_tick       = item.abs_tick;
  assign status_byte    = item.status_byte;
  assign meta_kind      = item.meta_kind;
  assign payload_length = item.payload_length;
  assign payload_byte   = item.payload_byte;
  assign last_of_event  = item.last_of_event;
  assign end_of_track   = item.end_of_track;
  assign error_code     = item.error_code;

endmodule

### sv/mtep_front.sv
`timescale 1ns / 1ps
// Front end: byte classifier and parse state, up to two result words per byte.
// Depends on mtep_pkg.
module mtep_front #(
  parameter int VARLEN_MAX_BYTES = mtep_pkg::VARLEN_MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               track_start,
  input  logic               track_end,
  output mtep_pkg::push_t    push
);

  mtep_pkg::phase_t phase, phase_next;
  logic [27:0] varlen_accum, varlen_accum_next;
  logic [1:0]  varlen_count, varlen_count_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  meta_type, meta_type_next;
  logic [31:0] tick_total, tick_total_next;
  logic [27:0] payload_left, payload_left_next;
  logic        track_done, track_done_next;

  always_comb begin
    mtep_pkg::res_t r [2];
    logic [1:0]  n;
    logic        again, stop, lastp, eot, running;
    logic [7:0]  st;
    logic [27:0] len;
    logic [32:0] sum;
    mtep_pkg::phase_t ph;
    logic [27:0] acc, left;
    logic [1:0]  cnt;
    logic [7:0]  rs, mt;
    logic [31:0] tick;
    logic        done;

    ph = phase; acc = varlen_accum; cnt = varlen_count; rs = running_status;
    mt = meta_type; tick = tick_total; left = payload_left; done = track_done;
    r[0] = '0; r[1] = '0; n = 2'd0;
    again = 1'b1; stop = 1'b0; lastp = 1'b0;
    st = 8'h00; len = 28'd0; sum = 33'd0; eot = 1'b0; running = 1'b0;

    if (track_start) begin
      ph = mtep_pkg::PH_DELTA; acc = '0; cnt = '0; rs = '0; mt = '0;
      tick = '0; left = '0; done = 1'b0;
    end

    if (!done) begin
      for (int p = 0; p < 2; p++) begin
        if (again && !stop) begin
          again = 1'b0;
          case (ph)
            mtep_pkg::PH_DELTA, mtep_pkg::PH_LENGTH: begin
              acc = {acc[20:0], data_byte[6:0]};
              if (!data_byte[7]) begin
                if (ph == mtep_pkg::PH_DELTA) begin
                  sum  = {1'b0, tick} + {5'b0, acc};
                  tick = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                  acc = '0; cnt = '0;
                  ph = mtep_pkg::PH_STATUS;
                end else begin
                  len = acc; acc = '0; cnt = '0;
                  eot = (rs == mtep_pkg::ST_META) && (mt == mtep_pkg::META_EOT);
                  if (len == 28'd0) begin
                    r[n[0]] = mtep_pkg::mk_res(mtep_pkg::KIND_HEADER, tick, rs, mt, 28'd0,
                                               8'h00, 1'b1, eot, mtep_pkg::ERR_NONE);
                    n = n + 2'd1;
                    if (eot) done = 1'b1;
                    ph = mtep_pkg::PH_DELTA; left = '0;
                  end else begin
                    r[n[0]] = mtep_pkg::mk_res(mtep_pkg::KIND_HEADER, tick, rs, mt, len,
                                               8'h00, 1'b0, eot, mtep_pkg::ERR_NONE);
                    n = n + 2'd1;
                    left = len;
                    ph = mtep_pkg::PH_PAYLOAD;
                  end
                end
              end else if (({1'b0, cnt} + 3'd1) >= 3'(VARLEN_MAX_BYTES)) begin
                r[n[0]] = mtep_pkg::mk_res(mtep_pkg::KIND_ERROR, tick, rs, mt, 28'd0,
                                           8'h00, 1'b1, 1'b0, mtep_pkg::ERR_VARLEN);
                n = n + 2'd1;
                done = 1'b1;
                stop = 1'b1;
              end else begin
                cnt = cnt + 2'd1;
              end
            end
            mtep_pkg::PH_STATUS: begin
              running = !data_byte[7];
              if (!running) rs = data_byte;
              st = rs;
              if (st == mtep_pkg::ST_META) begin
                ph = mtep_pkg::PH_METATYPE;
              end else if (st == mtep_pkg::ST_SYSEX || st == mtep_pkg::ST_ESCAPE) begin
                ph = mtep_pkg::PH_LENGTH; acc = '0; cnt = '0;
              end else if (st[7:4] == 4'hF) begin
                r[n[0]] = mtep_pkg::mk_res(mtep_pkg::KIND_HEADER, tick, rs, mt, 28'd0,
                                           8'h00, 1'b1, 1'b0, mtep_pkg::ERR_NONE);
                n = n + 2'd1;
                ph = mtep_pkg::PH_DELTA; acc = '0; cnt = '0; left = '0;
              end else begin
                len = (st[7:4] inside {4'hC, 4'hD} || !st[7]) ? 28'd1 : 28'd2;
                r[n[0]] = mtep_pkg::mk_res(mtep_pkg::KIND_HEADER, tick, rs, mt, len,
                                           8'h00, 1'b0, 1'b0, mtep_pkg::ERR_NONE);
                n = n + 2'd1;
                left = len;
                ph = mtep_pkg::PH_PAYLOAD;
              end
              again = running;
            end
            mtep_pkg::PH_METATYPE: begin
              mt = data_byte;
              ph = mtep_pkg::PH_LENGTH; acc = '0; cnt = '0;
            end
            mtep_pkg::PH_PAYLOAD: begin
              eot = (rs == mtep_pkg::ST_META) && (mt == mtep_pkg::META_EOT);
              if (left == 28'd0) begin
                if (eot) done = 1'b1;
                ph = mtep_pkg::PH_DELTA; acc = '0; cnt = '0; left = '0;
                again = 1'b1;
              end else begin
                left = left - 28'd1;
                r[n[0]] = mtep_pkg::mk_res(mtep_pkg::KIND_PAYLOAD, tick, rs, mt, 28'd0,
                                           data_byte, left == 28'd0, eot,
                                           mtep_pkg::ERR_NONE);
                n = n + 2'd1;
                lastp = 1'b1;
                if (left == 28'd0) begin
                  if (eot) done = 1'b1;
                  ph = mtep_pkg::PH_DELTA; acc = '0; cnt = '0;
                end
              end
            end
            default: begin
              ph = mtep_pkg::PH_DELTA; acc = '0; cnt = '0; left = '0;
              again = 1'b1;
            end
          endcase
        end
      end
    end

    if (track_end && !stop) begin
      if (!done && !(ph == mtep_pkg::PH_DELTA && cnt == 2'd0)) begin
        if (lastp && n != 2'd0) n = n - 2'd1;
        r[n[0]] = mtep_pkg::mk_res(mtep_pkg::KIND_ERROR, tick, rs, mt, left,
                                   lastp ? data_byte : 8'h00, 1'b1, 1'b0,
                                   mtep_pkg::ERR_TRUNCATED);
        n = n + 2'd1;
      end
      done = 1'b1;
    end

    push.count  = accept ? n : 2'd0;
    push.first  = r[0];
    push.second = r[1];
    phase_next = ph; varlen_accum_next = acc; varlen_count_next = cnt;
    running_status_next = rs; meta_type_next = mt; tick_total_next = tick;
    payload_left_next = left; track_done_next = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtep_pkg::PH_DELTA;
      varlen_accum   <= '0;
      varlen_count   <= '0;
      running_status <= '0;
      meta_type      <= '0;
      tick_total     <= '0;
      payload_left   <= '0;
      track_done     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      varlen_accum   <= varlen_accum_next;
      varlen_count   <= varlen_count_next;
      running_status <= running_status_next;
      meta_type      <= meta_type_next;
      tick_total     <= tick_total_next;
      payload_left   <= payload_left_next;
      track_done     <= track_done_next;
    end
  end

endmodule

### sv/mtep_queue.sv
`timescale 1ns / 1ps
// Result word queue between front and back: two writes, one read per cycle.
// Depends on mtep_pkg.
module mtep_queue (
  input  logic              clk,
  input  logic              rst,
  input  mtep_pkg::push_t   push,
  input  logic              pop,
  output mtep_pkg::res_t    head,
  output logic              nonempty,
  output logic              full
);

  localparam int AW = $clog2(mtep_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mtep_pkg::QUEUE_DEPTH + 1);

  mtep_pkg::res_t mem [mtep_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] wr_ptr1;

  assign wr_ptr1  = wr_ptr + AW'(1);
  assign head     = mem[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count > CW'(mtep_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(push.count) - CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mtep_pkg::QUEUE_DEPTH)) else $error("queue overfilled");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty) else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> !full) else $error("push without room");

endmodule

### sv/mtep_back.sv
`timescale 1ns / 1ps
// Back end: output register that drains the result queue.
// Depends on mtep_pkg.
module mtep_back (
  input  logic             clk,
  input  logic             rst,
  input  mtep_pkg::res_t   head,
  input  logic             nonempty,
  output logic             pop,
  input  logic             item_stall,
  output logic             item_valid,
  output mtep_pkg::res_t   item
);

  assign pop = nonempty && (!item_valid || !item_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      item_valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item <= head;
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for midi_track_event_parser_core: feeds track bytes and checks each
// result word against a built-in parser model, using a directed table and random tracks.
// Depends on mtep_pkg and the RTL of the parser.
module tb_top;

  localparam int STALL_LIMIT = 5000;
  localparam int VL_MORE = 0;
  localparam int VL_DONE = 1;
  localparam int VL_LONG = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        track_start = 1'b0;
  logic        track_end = 1'b0;
  logic        item_valid;
  logic        item_stall = 1'b0;
  logic [1:0]  item_kind;
  logic [31:0] abs_tick;
  logic [7:0]  status_byte;
  logic [7:0]  meta_kind;
  logic [27:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last_of_event;
  logic        end_of_track;
  logic [1:0]  error_code;

  midi_track_event_parser_core u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser state
  mtep_pkg::phase_t ph;
  logic [27:0] vl_acc;
  logic [1:0]  vl_cnt;
  logic [7:0]  run_st;
  logic [7:0]  mtype;
  logic [31:0] tick;
  logic [27:0] left;
  logic        done;

  mtep_pkg::res_t expected_words[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   sent = 0;
  int   burst_left = 0;

  typedef struct {
    logic [7:0]     b;
    logic           s;
    logic           e;
    bit             typed;
    mtep_pkg::res_t r;
  } row_t;

  row_t rows[$];

  task automatic parser_clear();
    ph = mtep_pkg::PH_DELTA; vl_acc = '0; vl_cnt = '0; run_st = '0;
    mtype = '0; tick = '0; left = '0; done = 1'b0;
  endtask

  function automatic logic is_eot();
    return run_st == mtep_pkg::ST_META && mtype == mtep_pkg::META_EOT;
  endfunction

  function automatic mtep_pkg::res_t word(logic [1:0] k, logic [27:0] pl, logic [7:0] pb,
                                          logic l, logic eot, logic [1:0] ec);
    mtep_pkg::res_t r;
    r.item_kind = k; r.abs_tick = tick; r.status_byte = run_st;
    r.meta_kind = (run_st == mtep_pkg::ST_META) ? mtype : 8'h00;
    r.payload_length = pl; r.payload_byte = pb;
    r.last_of_event = l; r.end_of_track = eot; r.error_code = ec;
    return r;
  endfunction

  task automatic close_event();
    if (is_eot()) done = 1'b1;
    ph = mtep_pkg::PH_DELTA; vl_acc = '0; vl_cnt = '0; left = '0;
  endtask

  function automatic int vl_step(logic [7:0] b);
    vl_acc = {vl_acc[20:0], b[6:0]};
    if (!b[7]) return VL_DONE;
    if (int'(vl_cnt) + 1 >= mtep_pkg::VARLEN_MAX_BYTES_DEF) return VL_LONG;
    vl_cnt = vl_cnt + 2'd1;
    return VL_MORE;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic s, input logic e);
    mtep_pkg::res_t out[$];
    bit again = 1, last_pl = 0, running;
    int r;
    logic [27:0] len;
    logic [32:0] sum;
    if (s) parser_clear();
    if (done) return;
    for (int p = 0; p < 2 && again; p++) begin
      again = 0;
      case (ph)
        mtep_pkg::PH_DELTA: begin
          r = vl_step(b);
          if (r == VL_LONG) begin
            foreach (out[i]) expected_words.push_back(out[i]);
            expected_words.push_back(word(mtep_pkg::KIND_ERROR, 28'd0, 8'h00, 1'b1, 1'b0,
                                          mtep_pkg::ERR_VARLEN));
            done = 1'b1;
            return;
          end
          if (r == VL_DONE) begin
            sum = {1'b0, tick} + {5'b0, vl_acc};
            tick = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            vl_acc = '0; vl_cnt = '0; ph = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          running = !b[7];
          if (!running) run_st = b;
          if (run_st == mtep_pkg::ST_META) ph = mtep_pkg::PH_METATYPE;
          else if (run_st == mtep_pkg::ST_SYSEX || run_st == mtep_pkg::ST_ESCAPE) begin
            ph = mtep_pkg::PH_LENGTH; vl_acc = '0; vl_cnt = '0;
          end else if (run_st[7:4] == 4'hF) begin
            out.push_back(word(mtep_pkg::KIND_HEADER, 28'd0, 8'h00, 1'b1, 1'b0,
                               mtep_pkg::ERR_NONE));
            close_event();
          end else begin
            len = (run_st[7:4] == 4'hC || run_st[7:4] == 4'hD || !run_st[7]) ? 28'd1 : 28'd2;
            out.push_back(word(mtep_pkg::KIND_HEADER, len, 8'h00, 1'b0, 1'b0,
                               mtep_pkg::ERR_NONE));
            left = len; ph = mtep_pkg::PH_PAYLOAD;
          end
          again = running;
        end
        mtep_pkg::PH_METATYPE: begin
          mtype = b; ph = mtep_pkg::PH_LENGTH; vl_acc = '0; vl_cnt = '0;
        end
        mtep_pkg::PH_LENGTH: begin
          r = vl_step(b);
          if (r == VL_LONG) begin
            foreach (out[i]) expected_words.push_back(out[i]);
            expected_words.push_back(word(mtep_pkg::KIND_ERROR, 28'd0, 8'h00, 1'b1, 1'b0,
                                          mtep_pkg::ERR_VARLEN));
            done = 1'b1;
            return;
          end
          if (r == VL_DONE) begin
            len = vl_acc; vl_acc = '0; vl_cnt = '0;
            out.push_back(word(mtep_pkg::KIND_HEADER, len, 8'h00, len == 28'd0, is_eot(),
                               mtep_pkg::ERR_NONE));
            if (len == 28'd0) close_event();
            else begin
              left = len; ph = mtep_pkg::PH_PAYLOAD;
            end
          end
        end
        default: begin
          if (ph != mtep_pkg::PH_PAYLOAD || left == 28'd0) begin
            close_event();
            again = 1;
          end else begin
            left = left - 28'd1;
            out.push_back(word(mtep_pkg::KIND_PAYLOAD, 28'd0, b, left == 28'd0, is_eot(),
                               mtep_pkg::ERR_NONE));
            last_pl = 1;
            if (left == 28'd0) close_event();
          end
        end
      endcase
    end
    if (e) begin
      if (!done && !(ph == mtep_pkg::PH_DELTA && vl_cnt == 2'd0)) begin
        if (last_pl && out.size() > 0) void'(out.pop_back());
        out.push_back(word(mtep_pkg::KIND_ERROR, left, last_pl ? b : 8'h00, 1'b1, 1'b0,
                           mtep_pkg::ERR_TRUNCATED));
      end
      done = 1'b1;
    end
    foreach (out[i]) expected_words.push_back(out[i]);
  endtask

  task automatic send(input logic [7:0] b, input logic s, input logic e);
    data_byte <= b; track_start <= s; track_end <= e; data_valid <= 1'b1;
    do @(posedge clk); while (data_stall);
    parse_byte(b, s, e);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_paced(input logic [7:0] b, input logic s, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        data_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send(b, s, e);
  endtask

  task automatic send_varlen(input logic [27:0] v, input bit first_start);
    int nb = 1;
    logic [7:0] b;
    for (int k = 1; k < 4; k++) if (v >> (7 * k)) nb = k + 1;
    for (int k = nb - 1; k >= 0; k--) begin
      b = {k != 0, 7'(v >> (7 * k))};
      send_paced(b, first_start && k == nb - 1, 1'b0);
    end
  endtask

  function automatic logic [27:0] rand_len();
    case ($urandom_range(0, 9))
      0: return 28'd0;
      1: return 28'($urandom_range(128, 300));
      default: return 28'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic random_track();
    int nev = $urandom_range(1, 12);
    logic [7:0] mt;
    logic [27:0] len;
    bit first = 1;
    for (int ev = 0; ev < nev; ev++) begin
      if ($urandom_range(0, 30) == 0) send_varlen(28'h0FFF_FFFF, first);
      else send_varlen(28'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)),
                       first);
      first = 0;
      case ($urandom_range(0, 9))
        0: begin
          send_paced(mtep_pkg::ST_META, 0, 0);
          mt = ($urandom_range(0, 2) == 0) ? mtep_pkg::META_EOT : 8'($urandom);
          send_paced(mt, 0, 0);
          len = rand_len();
          send_varlen(len, 0);
          for (int i = 0; i < len; i++) send_paced(8'($urandom), 0, 0);
        end
        1: begin
          send_paced($urandom_range(0, 1) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_ESCAPE, 0, 0);
          len = rand_len();
          send_varlen(len, 0);
          for (int i = 0; i < len; i++) send_paced(8'($urandom), 0, 0);
        end
        2: send_paced(8'($urandom_range(8'hF1, 8'hFE)), 0, 0);
        3: send_paced(8'($urandom), 0, $urandom_range(0, 3) == 0);
        default: begin
          if ($urandom_range(0, 2) != 0) send_paced(8'($urandom_range(8'h80, 8'hEF)), 0, 0);
          repeat (2) send_paced({1'b0, 7'($urandom)}, 0, 0);
        end
      endcase
    end
    send_paced(8'($urandom), 0, 1'b1);
  endtask

  task automatic add_row(logic [7:0] b, logic s, logic e);
    row_t r;
    r.b = b; r.s = s; r.e = e; r.typed = 0; r.r = '0;
    rows.push_back(r);
  endtask

  task automatic add_typed(logic [7:0] b, logic s, logic e, mtep_pkg::res_t w);
    row_t r;
    r.b = b; r.s = s; r.e = e; r.typed = 1; r.r = w;
    rows.push_back(r);
  endtask

  // receiver
  always @(posedge clk) begin
    mtep_pkg::res_t w;
    if (!rst && item_valid && !item_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word kind=%0d", item_kind);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (item_kind != w.item_kind) begin
          $error("item_kind exp %0h got %0h", w.item_kind, item_kind); errors++; end
        if (abs_tick != w.abs_tick) begin
          $error("abs_tick exp %0h got %0h", w.abs_tick, abs_tick); errors++; end
        if (status_byte != w.status_byte) begin
          $error("status_byte exp %0h got %0h", w.status_byte, status_byte); errors++; end
        if (meta_kind != w.meta_kind) begin
          $error("meta_kind exp %0h got %0h", w.meta_kind, meta_kind); errors++; end
        if (payload_length != w.payload_length) begin
          $error("payload_length exp %0h got %0h", w.payload_length, payload_length);
          errors++;
        end
        if (payload_byte != w.payload_byte) begin
          $error("payload_byte exp %0h got %0h", w.payload_byte, payload_byte); errors++; end
        if (last_of_event != w.last_of_event) begin
          $error("last_of_event exp %0b got %0b", w.last_of_event, last_of_event); errors++; end
        if (end_of_track != w.end_of_track) begin
          $error("end_of_track exp %0b got %0b", w.end_of_track, end_of_track); errors++; end
        if (error_code != w.error_code) begin
          $error("error_code exp %0h got %0h", w.error_code, error_code); errors++; end
      end
    end
  end

  // receiver stall pattern: quiet stretches, then random bursts of stall
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: item_stall <= 1'b0;
      1: item_stall <= ($urandom_range(0, 3) == 0);
      default: item_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if ((data_valid && !data_stall) || (item_valid && !item_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    mtep_pkg::res_t w;
    int base;
    parser_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: after reset no status -> header with one data byte
    w = mtep_pkg::mk_res(mtep_pkg::KIND_HEADER, 32'd0, 8'h00, 8'h00, 28'd1, 8'h00,
                         1'b0, 1'b0, mtep_pkg::ERR_NONE);
    add_row(8'h00, 0, 0);
    add_typed(8'h05, 0, 0, w);
    add_row(8'h7F, 0, 0);
    // max delta then note on, running status, program change, system status
    add_row(8'hFF, 1, 0); add_row(8'hFF, 0, 0); add_row(8'hFF, 0, 0); add_row(8'h7F, 0, 0);
    add_row(8'h90, 0, 0); add_row(8'h3C, 0, 0); add_row(8'h40, 0, 0);
    add_row(8'h00, 0, 0); add_row(8'h3E, 0, 0); add_row(8'h00, 0, 0);
    add_row(8'h00, 0, 0); add_row(8'hC5, 0, 0); add_row(8'h10, 0, 0);
    add_row(8'h00, 0, 0); add_row(8'hF1, 0, 0); add_row(8'h00, 0, 0);
    // sysex length 1 with payload byte F7
    add_row(8'hF0, 0, 0); add_row(8'h01, 0, 0); add_row(8'hF7, 0, 0);
    // varlen too long
    add_row(8'h00, 0, 0);
    add_row(8'h80, 1, 0); add_row(8'h80, 0, 0); add_row(8'h80, 0, 0);
    w = mtep_pkg::mk_res(mtep_pkg::KIND_ERROR, 32'd0, 8'h00, 8'h00, 28'd0, 8'h00,
                         1'b1, 1'b0, mtep_pkg::ERR_VARLEN);
    add_typed(8'h80, 0, 0, w);
    // truncated payload, then meta end-of-track
    add_row(8'h00, 1, 0); add_row(8'hB0, 0, 0); add_row(8'hAA, 0, 1);
    add_row(8'h00, 1, 0); add_row(8'hFF, 0, 0); add_row(8'h2F, 0, 0); add_row(8'h00, 0, 0);
    add_row(8'h00, 0, 0);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        base = expected_words.size();
        parse_byte(rows[i].b, rows[i].s, rows[i].e);
        if (expected_words.size() <= base) begin
          $error("directed row %0d: no word from model, table %h", i, rows[i].r);
          errors++;
        end else if (expected_words[base] != rows[i].r) begin
          $error("directed row %0d: model word %h, table %h", i, expected_words[base],
                 rows[i].r);
          errors++;
        end
        data_byte <= rows[i].b; track_start <= rows[i].s; track_end <= rows[i].e;
        data_valid <= 1'b1;
        do @(posedge clk); while (data_stall);
        sent++;
        @(negedge clk);
      end else begin
        send(rows[i].b, rows[i].s, rows[i].e);
      end
    end

    while (sent < 1000) begin
      if ($urandom_range(0, 9) == 0) begin
        send_paced(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
      end else begin
        random_track();
      end
    end
    data_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### midi_track_event_parser_core.f
sv/mtep_pkg.sv
sv/mtep_front.sv
sv/mtep_queue.sv
sv/mtep_back.sv
sv/midi_track_event_parser_core.sv
sim/tb_top.sv
